// File: src/spg_pkg.sv
// Shared types and fixed field widths for the Sobol point generator.
package spg_pkg;

    localparam int CMD_W       = 2;
    localparam int AMOUNT_W    = 32;
    localparam int DIM_FIELD_W = 4;
    localparam int BIT_FIELD_W = 5;
    localparam int DWORD_W     = 32;
    localparam int COUNT_W     = 5;
    localparam int POS_W       = 32;
    localparam int POS_IDX_W   = 5;
    localparam int FIFO_DEPTH  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_NEXT      = 2'd0,
        CMD_RESET_POS = 2'd1,
        CMD_SKIP      = 2'd2,
        CMD_WRITE     = 2'd3
    } command_t;

    // Position and table strobes, valid in the cycle a beat is accepted
    typedef struct packed {
        logic pos_incr;
        logic pos_clear;
        logic pos_skip;
        logic tbl_write;
    } pos_cmd_t;

    // One table/state read issued by the controller
    typedef struct packed {
        logic valid;
        logic scan;
        logic first;
        logic final_op;
        logic last;
    } issue_t;

endpackage

// File: src/spg_controller.sv
// Sequencer for the Sobol point generator: command decode and per-dimension read loop.
module spg_controller #(
    parameter int MAX_DIMENSIONS = 16,
    parameter int WORD_BITS      = 32,
    localparam int DIM_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1,
    localparam int BIT_W = $clog2(WORD_BITS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [spg_pkg::CMD_W-1:0]      command,
    output logic                           in_stall,
    input  logic                           cfg_write,
    input  logic [spg_pkg::COUNT_W-1:0]    cfg_data,
    input  logic                           space_ok,
    output spg_pkg::pos_cmd_t              pos_cmd,
    output spg_pkg::issue_t                issue,
    output logic [DIM_W-1:0]               issue_dim,
    output logic [BIT_W-1:0]               issue_bit
);
    import spg_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_INCR = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIM_W-1:0]     dim_reg, dim_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 dirty_reg, dirty_next;
    logic [DIM_W-1:0]     last_dim;
    logic                 dim_is_last;
    logic                 bit_is_last;

    // Clamp the dimension count to 1..MAX_DIMENSIONS
    always_comb
    begin
        if (count_reg == '0)
        begin
            last_dim = '0;
        end
        else if (int'(count_reg) > MAX_DIMENSIONS)
        begin
            last_dim = DIM_W'(MAX_DIMENSIONS - 1);
        end
        else
        begin
            last_dim = DIM_W'(count_reg - 1'b1);
        end
    end

    assign dim_is_last = (dim_reg == last_dim);
    assign bit_is_last = (bit_reg == BIT_W'(WORD_BITS - 1));
    assign in_stall    = (state_reg != ST_IDLE);
    assign issue_dim   = dim_reg;
    assign issue_bit   = bit_reg;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        dim_next   = dim_reg;
        bit_next   = bit_reg;
        count_next = count_reg;
        dirty_next = dirty_reg;
        pos_cmd    = '0;
        issue      = '0;

        // A count write invalidates the stored per-dimension values, unless it comes with the last read of a rebuild
        if (cfg_write)
        begin
            count_next = cfg_data;
            dirty_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (command)
                        CMD_NEXT:
                        begin
                            pos_cmd.pos_incr = 1'b1;
                            state_next       = ST_PREP;
                        end
                        CMD_RESET_POS:
                        begin
                            pos_cmd.pos_clear = 1'b1;
                            dirty_next        = 1'b1;
                        end
                        CMD_SKIP:
                        begin
                            pos_cmd.pos_skip = 1'b1;
                            dirty_next       = 1'b1;
                        end
                        default:
                        begin
                            pos_cmd.tbl_write = 1'b1;
                            dirty_next        = 1'b1;
                        end
                    endcase
                end
            end
            ST_PREP:
            begin
                dim_next   = '0;
                bit_next   = '0;
                state_next = dirty_reg ? ST_SCAN : ST_INCR;
            end
            ST_INCR:
            begin
                // One read per dimension: flip the single changed Gray bit
                issue.first    = 1'b1;
                issue.final_op = 1'b1;
                issue.last     = dim_is_last;
                if (space_ok)
                begin
                    issue.valid = 1'b1;
                    if (dim_is_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        dim_next = dim_reg + 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // Full rebuild: walk every direction word of every active dimension
                issue.scan     = 1'b1;
                issue.first    = (bit_reg == '0);
                issue.final_op = bit_is_last;
                issue.last     = dim_is_last;
                if (!bit_is_last || space_ok)
                begin
                    issue.valid = 1'b1;
                    if (bit_is_last)
                    begin
                        bit_next = '0;
                        if (dim_is_last)
                        begin
                            state_next = ST_DONE;
                            dirty_next = 1'b0;
                        end
                        else
                        begin
                            dim_next = dim_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        bit_next = bit_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                // Let the last state write land before the next beat
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dim_reg   <= '0;
            bit_reg   <= '0;
            count_reg <= COUNT_W'(1);
            dirty_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            dim_reg   <= dim_next;
            bit_reg   <= bit_next;
            count_reg <= count_next;
            dirty_reg <= dirty_next;
        end
    end

endmodule

// File: src/spg_datapath.sv
// Datapath for the Sobol point generator: position, direction table, XOR stage, output queue.
module spg_datapath #(
    parameter int MAX_DIMENSIONS = 16,
    parameter int WORD_BITS      = 32,
    localparam int DIM_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1,
    localparam int BIT_W = $clog2(WORD_BITS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spg_pkg::pos_cmd_t                 pos_cmd,
    input  spg_pkg::issue_t                   issue,
    input  logic [DIM_W-1:0]                  issue_dim,
    input  logic [BIT_W-1:0]                  issue_bit,
    input  logic [spg_pkg::AMOUNT_W-1:0]      amount,
    input  logic [spg_pkg::DIM_FIELD_W-1:0]   dim_index,
    input  logic [spg_pkg::BIT_FIELD_W-1:0]   bit_index,
    input  logic [spg_pkg::DWORD_W-1:0]       direction_word,
    output logic                              space_ok,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [spg_pkg::DIM_FIELD_W-1:0]   dimension,
    output logic [WORD_BITS:0]                sample,
    output logic                              last
);
    import spg_pkg::*;

    localparam int TBL_DEPTH = MAX_DIMENSIONS * WORD_BITS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int FIFO_PW   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW   = $clog2(FIFO_DEPTH + 1);

    // Position and Gray code
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      gray_prev_reg;
    logic [POS_W-1:0]      gray_cur;
    logic [POS_W-1:0]      gray_diff;
    logic [POS_IDX_W-1:0]  chg_idx;
    logic [POS_IDX_W-1:0]  chg_idx_reg;
    logic                  chg_use;

    // Table and per-dimension running values
    logic [WORD_BITS-1:0]  tbl_mem [TBL_DEPTH];
    logic [WORD_BITS-1:0]  acc_mem [MAX_DIMENSIONS];
    logic                  wr_ok;
    logic [TBL_AW-1:0]     wr_addr;
    logic [BIT_W-1:0]      rd_bit;
    logic [TBL_AW-1:0]     rd_addr;
    logic                  rd_use;
    logic [WORD_BITS-1:0]  tbl_q_reg;
    logic [WORD_BITS-1:0]  state_q_reg;

    // XOR stage
    logic                  valid_b_reg;
    logic                  first_b_reg;
    logic                  final_b_reg;
    logic                  last_b_reg;
    logic                  use_b_reg;
    logic                  from_state_b_reg;
    logic [DIM_W-1:0]      dim_b_reg;
    logic [WORD_BITS-1:0]  acc_reg;
    logic [WORD_BITS-1:0]  base;
    logic [WORD_BITS-1:0]  val;
    logic                  push;

    // Output queue
    logic [DIM_FIELD_W-1:0] fifo_dim_reg    [FIFO_DEPTH];
    logic [WORD_BITS:0]     fifo_sample_reg [FIFO_DEPTH];
    logic                   fifo_last_reg   [FIFO_DEPTH];
    logic [FIFO_PW-1:0]     wr_ptr_reg;
    logic [FIFO_PW-1:0]     rd_ptr_reg;
    logic [FIFO_CW-1:0]     count_reg;
    logic                   pop;

    assign gray_cur  = pos_reg ^ (pos_reg >> 1);
    assign gray_diff = gray_cur ^ gray_prev_reg;

    // Encode the single Gray bit that changed on the last increment
    always_comb
    begin
        chg_idx = '0;
        for (int i = 0; i < POS_W; i++)
        begin
            if (gray_diff[i])
            begin
                chg_idx = chg_idx | POS_IDX_W'(i);
            end
        end
    end

    assign chg_use = (int'(chg_idx_reg) < WORD_BITS);

    // Advance, clear or skip the position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (pos_cmd.pos_clear)
        begin
            pos_reg <= '0;
        end
        else if (pos_cmd.pos_skip)
        begin
            pos_reg <= pos_reg + amount;
        end
        else if (pos_cmd.pos_incr)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    // Hold the previous Gray code and register the changed bit index
    always_ff @(posedge clk)
    begin
        if (pos_cmd.pos_incr)
        begin
            gray_prev_reg <= gray_cur;
        end
        chg_idx_reg <= chg_idx;
    end

    // Table write address; out-of-range writes are dropped
    assign wr_ok = pos_cmd.tbl_write
                   && (int'(dim_index) < MAX_DIMENSIONS)
                   && (int'(bit_index) < WORD_BITS);
    assign wr_addr = TBL_AW'(dim_index) * TBL_AW'(WORD_BITS) + TBL_AW'(bit_index);

    // Read address and select for the issued read
    assign rd_bit  = issue.scan ? issue_bit : BIT_W'(chg_idx_reg);
    assign rd_addr = TBL_AW'(issue_dim) * TBL_AW'(WORD_BITS) + TBL_AW'(rd_bit);
    assign rd_use  = issue.scan ? gray_cur[issue_bit] : chg_use;

    // Direction table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            tbl_mem[wr_addr] <= direction_word[WORD_BITS-1:0];
        end
        if (issue.valid)
        begin
            tbl_q_reg <= tbl_mem[rd_addr];
        end
    end

    // Per-dimension values at the current position
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            acc_mem[dim_b_reg] <= val;
        end
        if (issue.valid)
        begin
            state_q_reg <= acc_mem[issue_dim];
        end
    end

    // Carry the read's tags into the XOR stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_b_reg <= issue.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            first_b_reg      <= issue.first;
            final_b_reg      <= issue.final_op;
            last_b_reg       <= issue.last;
            use_b_reg        <= rd_use;
            from_state_b_reg <= !issue.scan;
            dim_b_reg        <= issue_dim;
        end
    end

    // XOR the selected direction word into the running value
    always_comb
    begin
        if (from_state_b_reg)
        begin
            base = state_q_reg;
        end
        else if (first_b_reg)
        begin
            base = '0;
        end
        else
        begin
            base = acc_reg;
        end
        val = base ^ (use_b_reg ? tbl_q_reg : '0);
    end

    assign push = valid_b_reg && final_b_reg;

    always_ff @(posedge clk)
    begin
        if (valid_b_reg)
        begin
            acc_reg <= val;
        end
    end

    // Output queue control
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign space_ok  = (count_reg - FIFO_CW'(pop) + FIFO_CW'(push))
                       < FIFO_CW'(FIFO_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
        end
    end

    // Store a finished sample as 2*value+1
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_dim_reg[wr_ptr_reg]    <= DIM_FIELD_W'(dim_b_reg);
            fifo_sample_reg[wr_ptr_reg] <= {val, 1'b1};
            fifo_last_reg[wr_ptr_reg]   <= last_b_reg;
        end
    end

    assign dimension = fifo_dim_reg[rd_ptr_reg];
    assign sample    = fifo_sample_reg[rd_ptr_reg];
    assign last      = fifo_last_reg[rd_ptr_reg];

endmodule

// File: src/sobol_point_generator_core.sv
// Sobol point generator: command input, one sample per dimension on the output.
//
// Input channel (in_valid/in_stall) takes one command beat: next point, reset
// position, skip ahead by amount, or write one direction word of the table.
// Output channel (out_valid/out_stall) carries one beat per active dimension
// for each next command, in dimension order, with last set on the final one.
// cfg_write loads the dimension count (clamped to 1..MAX_DIMENSIONS).
// A next command does one direction-table read per dimension (the changed
// Gray bit only) when the stored per-dimension values are current. After
// reset, a position reset, a skip, a table write or a count write, the next
// point rebuilds every value: WORD_BITS table reads per dimension, one table
// read per cycle through the single table read port while the output queue
// has room. A sample passes from its read through the registered table read
// into the output queue. Reset clears the position and sets the count to
// one; the table holds garbage until written. A stalled receiver fills a
// two-beat output queue and then pauses the read loop; no beat is lost.
module sobol_point_generator_core #(
    parameter int MAX_DIMENSIONS = 16,
    parameter int WORD_BITS      = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [spg_pkg::CMD_W-1:0]         command,
    input  logic [spg_pkg::AMOUNT_W-1:0]      amount,
    input  logic [spg_pkg::DIM_FIELD_W-1:0]   dim_index,
    input  logic [spg_pkg::BIT_FIELD_W-1:0]   bit_index,
    input  logic [spg_pkg::DWORD_W-1:0]       direction_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [spg_pkg::DIM_FIELD_W-1:0]   dimension,
    output logic [WORD_BITS:0]                sample,
    output logic                              last,
    input  logic                              cfg_write,
    input  logic [spg_pkg::COUNT_W-1:0]       cfg_data
);
    import spg_pkg::*;

    localparam int DIM_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
    localparam int BIT_W = $clog2(WORD_BITS);

    pos_cmd_t           pos_cmd;
    issue_t             issue;
    logic [DIM_W-1:0]   issue_dim;
    logic [BIT_W-1:0]   issue_bit;
    logic               space_ok;

    spg_controller #(
        .MAX_DIMENSIONS (MAX_DIMENSIONS),
        .WORD_BITS      (WORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .in_stall  (in_stall),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .space_ok  (space_ok),
        .pos_cmd   (pos_cmd),
        .issue     (issue),
        .issue_dim (issue_dim),
        .issue_bit (issue_bit)
    );

    spg_datapath #(
        .MAX_DIMENSIONS (MAX_DIMENSIONS),
        .WORD_BITS      (WORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .pos_cmd        (pos_cmd),
        .issue          (issue),
        .issue_dim      (issue_dim),
        .issue_bit      (issue_bit),
        .amount         (amount),
        .dim_index      (dim_index),
        .bit_index      (bit_index),
        .direction_word (direction_word),
        .space_ok       (space_ok),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dimension      (dimension),
        .sample         (sample),
        .last           (last)
    );

    // A next beat starts the read loop, so the input must stall right after
    a_next_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && command == CMD_NEXT) |=> in_stall)
        else $error("input not stalled after next command");

    // A sample is only produced when the output queue has room for it
    a_final_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (issue.valid && issue.final_op) |-> space_ok)
        else $error("sample issued without output queue space");

    // Reads never overlap with accepting a new beat
    a_issue_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> in_stall)
        else $error("table read issued while input is open");

endmodule

// File: tb/sobol_point_generator_core_tb.sv
// Self-checking testbench for the Sobol point generator core.
`timescale 1ns / 100ps

module sobol_point_generator_core_tb;
    import spg_pkg::*;

    localparam int MAX_DIMS       = 16;
    localparam int WORD_BITS      = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 6;
    localparam int PRELOAD_BITS   = 3;
    localparam int POS_LIMIT      = 7;

    // One output beat: dimension, fraction, point end
    typedef struct packed {
        logic [DIM_FIELD_W-1:0] dim;
        logic [WORD_BITS:0]     frac;
        logic                   tail;
    } sample_beat_t;

    // One directed command; want is typed in only where it is obvious
    typedef struct packed {
        command_t               op;
        logic [AMOUNT_W-1:0]    amt;
        logic [DIM_FIELD_W-1:0] dim;
        logic [BIT_FIELD_W-1:0] sel;
        logic [DWORD_W-1:0]     word;
        logic                   typed;
        logic [WORD_BITS:0]     want;
    } script_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [CMD_W-1:0]       command;
    logic [AMOUNT_W-1:0]    amount;
    logic [DIM_FIELD_W-1:0] dim_index;
    logic [BIT_FIELD_W-1:0] bit_index;
    logic [DWORD_W-1:0]     direction_word;
    logic                   out_valid;
    logic                   out_stall;
    logic [DIM_FIELD_W-1:0] dimension;
    logic [WORD_BITS:0]     sample;
    logic                   last;
    logic                   cfg_write;
    logic [COUNT_W-1:0]     cfg_data;

    // Generator state mirrored by the testbench
    logic [POS_W-1:0]       sobol_pos;
    logic [COUNT_W-1:0]     dim_count;
    logic [WORD_BITS-1:0]   direction_tbl [MAX_DIMS][WORD_BITS];
    sample_beat_t           pending_samples [$];
    int                     error_count = 0;
    int                     quiet_cycles = 0;

    // Directed commands, count at its reset value of one
    script_row_t script [20] = '{
        '{CMD_WRITE,     32'h0,         4'd0,  5'd0,  32'hFFFF_FFFF, 1'b0, 33'h0},
        '{CMD_NEXT,      32'h0,         4'd0,  5'd0,  32'h0,         1'b1, 33'h1_FFFF_FFFF},
        '{CMD_WRITE,     32'h0,         4'd0,  5'd1,  32'h0,         1'b0, 33'h0},
        '{CMD_NEXT,      32'h0,         4'd0,  5'd0,  32'h0,         1'b1, 33'h1_FFFF_FFFF},
        '{CMD_WRITE,     32'h0,         4'd0,  5'd0,  32'h0,         1'b0, 33'h0},
        '{CMD_NEXT,      32'h0,         4'd0,  5'd0,  32'h0,         1'b1, 33'h1},
        '{CMD_RESET_POS, 32'h0,         4'd0,  5'd0,  32'h0,         1'b0, 33'h0},
        '{CMD_NEXT,      32'h0,         4'd0,  5'd0,  32'h0,         1'b1, 33'h1},
        '{CMD_SKIP,      32'h0,         4'd0,  5'd0,  32'h0,         1'b0, 33'h0},
        '{CMD_NEXT,      32'h0,         4'd0,  5'd0,  32'h0,         1'b1, 33'h1},
        '{CMD_SKIP,      32'hFFFF_FFFF, 4'd0,  5'd0,  32'h0,         1'b0, 33'h0},
        '{CMD_NEXT,      32'h0,         4'd0,  5'd0,  32'h0,         1'b1, 33'h1},
        '{CMD_WRITE,     32'h0,         4'd0,  5'd31, 32'h8000_0001, 1'b0, 33'h0},
        '{CMD_RESET_POS, 32'h0,         4'd0,  5'd0,  32'h0,         1'b0, 33'h0},
        '{CMD_SKIP,      32'hFFFF_FFFE, 4'd0,  5'd0,  32'h0,         1'b0, 33'h0},
        '{CMD_NEXT,      32'h0,         4'd0,  5'd0,  32'h0,         1'b1, 33'h1_0000_0003},
        '{CMD_NEXT,      32'hFFFF_FFFF, 4'd15, 5'd31, 32'hFFFF_FFFF, 1'b1, 33'h1},
        '{CMD_WRITE,     32'hFFFF_FFFF, 4'd15, 5'd31, 32'hFFFF_FFFF, 1'b0, 33'h0},
        '{CMD_SKIP,      32'd5,         4'd0,  5'd0,  32'h0,         1'b0, 33'h0},
        '{CMD_NEXT,      32'h0,         4'd0,  5'd0,  32'h0,         1'b0, 33'h0}
    };

    sobol_point_generator_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .amount         (amount),
        .dim_index      (dim_index),
        .bit_index      (bit_index),
        .direction_word (direction_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dimension      (dimension),
        .sample         (sample),
        .last           (last),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data)
    );

    // Free-running clock, 10 ns period
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Append one expected beat at the tail of the queue
    function automatic void enqueue_sample(input sample_beat_t beat);
        pending_samples.insert(pending_samples.size(), beat);
    endfunction

    // Advance the mirrored generator by one command; queue the samples of a next point
    task automatic advance_sobol(input command_t op, input logic [AMOUNT_W-1:0] amt,
                                 input logic [DIM_FIELD_W-1:0] dim,
                                 input logic [BIT_FIELD_W-1:0] sel,
                                 input logic [DWORD_W-1:0] word, input bit record);
        logic [POS_W-1:0]     gray;
        logic [WORD_BITS-1:0] acc;
        int                   n;
        sample_beat_t         beat;
        case (op)
            CMD_RESET_POS: sobol_pos = '0;
            CMD_SKIP:      sobol_pos = sobol_pos + amt;
            CMD_WRITE:     direction_tbl[dim][sel] = word;
            default:
            begin
                sobol_pos = sobol_pos + 1'b1;
                gray = sobol_pos ^ (sobol_pos >> 1);
                // saturate the count to 1..MAX_DIMS
                n = (dim_count == 0) ? 1 : (dim_count > MAX_DIMS) ? MAX_DIMS : int'(dim_count);
                for (int d = 0; d < n; d++)
                begin
                    acc = '0;
                    for (int b = 0; b < WORD_BITS; b++)
                        if (gray[b])
                            acc ^= direction_tbl[d][b];
                    beat.dim  = DIM_FIELD_W'(d);
                    beat.frac = {acc, 1'b1};
                    beat.tail = (d == n - 1);
                    if (record)
                        enqueue_sample(beat);
                end
            end
        endcase
    endtask

    // Send one command beat after a random gap, then update the mirror on acceptance
    task automatic send_command(input command_t op, input logic [AMOUNT_W-1:0] amt,
                                input logic [DIM_FIELD_W-1:0] dim,
                                input logic [BIT_FIELD_W-1:0] sel,
                                input logic [DWORD_W-1:0] word, input bit record);
        int pick;
        int gap;
        pick = $urandom_range(99);
        gap = (pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        command        <= op;
        amount         <= amt;
        dim_index      <= dim;
        bit_index      <= sel;
        direction_word <= word;
        do
            @(posedge clk);
        while (in_stall);
        advance_sobol(op, amt, dim, sel, word, record);
    endtask

    // Hold the sender until every queued sample has come, then let the block settle
    task automatic drain_samples();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Receiver back-pressure: ready runs, then often no stall, some short and a few long stalls
    initial
    begin : stall_gen
        int run;
        int pick;
        int len;
        out_stall = 1'b0;
        forever
        begin
            run = $urandom_range(1, 24);
            repeat (run) @(negedge clk) out_stall <= 1'b0;
            pick = $urandom_range(99);
            len = (pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 4) : $urandom_range(12, 45);
            repeat (len) @(negedge clk) out_stall <= 1'b1;
        end
    end

    // Check each output beat against the oldest queued sample; watchdog on silence
    always @(posedge clk)
    begin : sample_check
        sample_beat_t exp_beat;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_samples.size() == 0)
                begin
                    $error("unexpected sample beat: dimension %0d sample 0x%0h last %0b",
                           dimension, sample, last);
                    error_count++;
                end
                else
                begin
                    exp_beat = pending_samples.pop_front();
                    if (dimension !== exp_beat.dim)
                    begin
                        $error("dimension mismatch: expected %0d, actual %0d",
                               exp_beat.dim, dimension);
                        error_count++;
                    end
                    if (sample !== exp_beat.frac)
                    begin
                        $error("sample mismatch: expected 0x%0h, actual 0x%0h",
                               exp_beat.frac, sample);
                        error_count++;
                    end
                    if (last !== exp_beat.tail)
                    begin
                        $error("last mismatch: expected %0b, actual %0b", exp_beat.tail, last);
                        error_count++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                quiet_cycles = 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT - 1)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles++;
        end
    end

    // Stimulus: reset, table preload, directed script, then random phases per count
    initial
    begin : stimulus
        logic [COUNT_W-1:0]     count_plan [7];
        int                     pick;
        command_t               op;
        logic [AMOUNT_W-1:0]    amt;
        logic [BIT_FIELD_W-1:0] sel;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_NEXT;
        amount         = '0;
        dim_index      = '0;
        bit_index      = '0;
        direction_word = '0;
        cfg_write      = 1'b0;
        cfg_data       = '0;
        sobol_pos      = '0;
        dim_count      = COUNT_W'(1);
        count_plan     = '{5'd16, 5'd0, 5'd31, 5'd2, 5'd0, 5'd0, 5'd1};
        count_plan[4]  = COUNT_W'($urandom_range(3, 15));
        count_plan[5]  = COUNT_W'($urandom_range(17, 30));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill the low direction words of every dimension; the random part keeps
        // the position small so no point reads past them
        for (int d = 0; d < MAX_DIMS; d++)
            for (int b = 0; b < PRELOAD_BITS; b++)
                send_command(CMD_WRITE, $urandom, DIM_FIELD_W'(d), BIT_FIELD_W'(b), $urandom,
                             1'b1);

        // directed part
        foreach (script[i])
        begin
            send_command(script[i].op, script[i].amt, script[i].dim, script[i].sel,
                         script[i].word, !script[i].typed);
            if (script[i].typed)
                enqueue_sample('{dim: '0, frac: script[i].want, tail: 1'b1});
        end

        // random phases, one dimension count each
        foreach (count_plan[p])
        begin
            drain_samples();
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_data  <= count_plan[p];
            @(negedge clk);
            cfg_write <= 1'b0;
            dim_count = count_plan[p];
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pick = $urandom_range(99);
                op = (pick < 55) ? CMD_NEXT : (pick < 75) ? CMD_WRITE :
                     (pick < 87) ? CMD_SKIP : CMD_RESET_POS;
                // hold the position at or below POS_LIMIT
                if (op == CMD_NEXT && sobol_pos >= POS_W'(POS_LIMIT))
                    op = CMD_RESET_POS;
                amt = AMOUNT_W'($urandom_range(0, POS_LIMIT - int'(sobol_pos)));
                sel = ($urandom_range(3) != 0) ? BIT_FIELD_W'($urandom_range(0, PRELOAD_BITS - 1))
                                               : BIT_FIELD_W'($urandom);
                send_command(op, amt, DIM_FIELD_W'($urandom), sel, $urandom, 1'b1);
                // occasionally hold off until the output side has caught up
                if ($urandom_range(99) < 6)
                    drain_samples();
            end
        end

        drain_samples();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
